// File: rtl/puit_pkg.sv
// ----------------------------------------------------------------------------
// puit_pkg
// shared types and codes for the per-unit interval timeline
// ----------------------------------------------------------------------------
package puit_pkg;

   typedef enum logic [1:0] {
      FUNC_PUSH   = 2'd0,
      FUNC_INSERT = 2'd1,
      FUNC_REBASE = 2'd2,
      FUNC_LOOKUP = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STAT_DONE  = 2'd0,
      STAT_NONE  = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] begin_clk;
      logic [31:0] length;
      logic [15:0] rowid;
   } slot_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_PUT,
      ST_REB_RD,
      ST_REB_WR,
      ST_RESP
   } state_type;

endpackage

// File: rtl/puit_mem.sv
// ----------------------------------------------------------------------------
// puit_mem
// slot storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module puit_mem
   import puit_pkg::*;
#(
   parameter int unsigned ADDR_W = 9
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  slot_type          wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output slot_type          rd_data
);

   slot_type mem [0:(1<<ADDR_W)-1];
   slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/per_unit_interval_timeline.sv
// ----------------------------------------------------------------------------
// per_unit_interval_timeline
// per-unit ordered lists of timed entries: push, insert with split, rebase,
// lookup
// ----------------------------------------------------------------------------
// req_ channel carries one command beat; rsp_ returns exactly one status beat
// per command, in order. one command is worked at a time; req_ready is high
// while the sequencer is idle, also while a response waits on rsp_.
// all slots live in one memory with one write and one registered read port,
// so each entry read takes a read state and then a write or check state:
//   push   : write the slot, then respond
//   lookup : read and check entries in order until one covers the clock
//   insert : scan as lookup, shift later entries up, write the new slots
//   rebase : read and rewrite each stored entry of every unit in order
// reset clears the fill counts and the sequencer; slot contents are not
// cleared since only slots below a fill count are ever read.
// a stalled rsp_ holds its beat in the output register; the next command is
// worked meanwhile and then waits in the sequencer until that beat is taken.
// ----------------------------------------------------------------------------
module per_unit_interval_timeline
   import puit_pkg::*;
#(
   parameter int unsigned NUM_UNITS  = 16,
   parameter int unsigned LIST_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [3:0]  req_unit_index,
   input  logic [1:0]  req_entry_kind,
   input  logic [31:0] req_entry_begin,
   input  logic [31:0] req_entry_length,
   input  logic [15:0] req_entry_rowid,
   input  logic [31:0] req_at_clock,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [1:0]  rsp_found_kind,
   output logic [31:0] rsp_found_begin,
   output logic [31:0] rsp_found_length,
   output logic [15:0] rsp_found_rowid
);

   localparam int unsigned UW = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
   localparam int unsigned PW = $clog2(LIST_DEPTH);
   localparam int unsigned FW = $clog2(LIST_DEPTH + 1);
   localparam int unsigned AW = UW + PW;

   state_type           state_ff, state_in;
   logic [FW-1:0]       fill_ff [0:NUM_UNITS-1];
   logic                fill_we;
   logic [FW-1:0]       fill_wv;
   logic [UW-1:0]       unit_ff, unit_in;
   logic [FW-1:0]       pos_ff, pos_in;
   logic [FW-1:0]       tgt_ff, tgt_in;
   logic [1:0]          gap_ff, gap_in;
   logic [1:0]          puts_ff, puts_in;
   logic                split_ff, split_in;
   logic [31:0]         cur_ff, cur_in;
   slot_type            old_ff, old_in;
   func_type            func_ff, func_in;
   logic [1:0]          kind_ff;
   logic [31:0]         nbeg_ff, nlen_ff, clk_ff;
   logic [15:0]         row_ff;
   logic [1:0]          stat_ff, stat_in;
   slot_type            found_ff, found_in;
   logic                rv_ff, rv_in;
   logic                out_load;
   logic [1:0]          out_stat_ff;
   slot_type            out_found_ff;

   logic                wr_en;
   logic [AW-1:0]       wr_addr, rd_addr;
   slot_type            wr_data, rd_data;
   logic [FW-1:0]       fill_cur;
   logic                unit_ok;
   logic [32:0]         span;
   logic                cov;

   puit_mem #(.ADDR_W(AW)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign fill_cur = fill_ff[unit_ff];
   assign unit_ok  = ({28'd0, req_unit_index} < 32'(NUM_UNITS));
   assign span     = {1'b0, clk_ff} - {1'b0, rd_data.begin_clk};
   assign cov      = (clk_ff >= rd_data.begin_clk) && (span < {1'b0, rd_data.length});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff    <= 1'b0;
         for (int i = 0; i < NUM_UNITS; i++) begin
            fill_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         if (fill_we) begin
            fill_ff[unit_ff] <= fill_wv;
         end
      end
      unit_ff  <= unit_in;
      pos_ff   <= pos_in;
      tgt_ff   <= tgt_in;
      gap_ff   <= gap_in;
      puts_ff  <= puts_in;
      split_ff <= split_in;
      cur_ff   <= cur_in;
      old_ff   <= old_in;
      func_ff  <= func_in;
      stat_ff  <= stat_in;
      found_ff <= found_in;
      if (out_load) begin
         out_stat_ff  <= stat_ff;
         out_found_ff <= found_ff;
      end
      if (req_valid && req_ready) begin
         kind_ff <= req_entry_kind;
         nbeg_ff <= req_entry_begin;
         nlen_ff <= req_entry_length;
         row_ff  <= req_entry_rowid;
         clk_ff  <= req_at_clock;
      end
   end

   always_comb begin
      state_in = state_ff;
      unit_in  = unit_ff;
      pos_in   = pos_ff;
      tgt_in   = tgt_ff;
      gap_in   = gap_ff;
      puts_in  = puts_ff;
      split_in = split_ff;
      cur_in   = cur_ff;
      old_in   = old_ff;
      func_in  = func_ff;
      stat_in  = stat_ff;
      found_in = found_ff;
      rv_in    = rv_ff;
      out_load = 1'b0;
      fill_we  = 1'b0;
      fill_wv  = fill_cur;
      wr_en    = 1'b0;
      wr_addr  = {unit_ff, pos_ff[PW-1:0]};
      wr_data  = '{kind: kind_ff, begin_clk: nbeg_ff, length: nlen_ff, rowid: row_ff};
      rd_addr  = {unit_ff, pos_ff[PW-1:0]};
      req_ready = (state_ff == ST_IDLE);
      if (rv_ff && rsp_ready) begin
         rv_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               func_in  = func_type'(req_func);
               unit_in  = UW'(req_unit_index);
               pos_in   = '0;
               stat_in  = STAT_DONE;
               found_in = '0;
               case (func_type'(req_func))
                  FUNC_PUSH: begin
                     if (!unit_ok || fill_ff[UW'(req_unit_index)] >= FW'(LIST_DEPTH)) begin
                        stat_in  = STAT_FULL;
                        state_in = ST_RESP;
                     end else begin
                        pos_in   = fill_ff[UW'(req_unit_index)];
                        puts_in  = 2'd1;
                        split_in = 1'b0;
                        state_in = ST_PUT;
                     end
                  end
                  FUNC_REBASE: begin
                     unit_in  = '0;
                     cur_in   = req_at_clock;
                     state_in = ST_REB_RD;
                  end
                  default: begin
                     if (!unit_ok) begin
                        stat_in  = STAT_NONE;
                        state_in = ST_RESP;
                     end else begin
                        state_in = ST_SCAN_RD;
                     end
                  end
               endcase
            end
         end
         ST_SCAN_RD: begin
            if (pos_ff >= fill_cur) begin
               stat_in  = STAT_NONE;
               state_in = ST_RESP;
            end else begin
               state_in = ST_SCAN_CHK;
            end
         end
         ST_SCAN_CHK: begin
            if (!cov) begin
               pos_in   = pos_ff + 1'b1;
               state_in = ST_SCAN_RD;
            end else if (func_ff == FUNC_LOOKUP) begin
               found_in = rd_data;
               state_in = ST_RESP;
            end else if (clk_ff == rd_data.begin_clk) begin
               if ({1'b0, fill_cur} + 1'b1 > (FW+1)'(LIST_DEPTH)) begin
                  stat_in  = STAT_FULL;
                  state_in = ST_RESP;
               end else begin
                  gap_in   = 2'd1;
                  split_in = 1'b0;
                  puts_in  = 2'd1;
                  tgt_in   = pos_ff;
                  pos_in   = fill_cur;
                  state_in = ST_SHIFT_RD;
               end
            end else begin
               if ({1'b0, fill_cur} + 2'd2 > (FW+1)'(LIST_DEPTH)) begin
                  stat_in  = STAT_FULL;
                  state_in = ST_RESP;
               end else begin
                  gap_in   = 2'd2;
                  split_in = 1'b1;
                  puts_in  = 2'd3;
                  old_in   = rd_data;
                  tgt_in   = pos_ff + 1'b1;
                  pos_in   = fill_cur;
                  state_in = ST_SHIFT_RD;
               end
            end
         end
         // pos_ff counts down; entry pos_ff-1 moves up by gap_ff
         ST_SHIFT_RD: begin
            rd_addr = {unit_ff, PW'(pos_ff - 1'b1)};
            if (pos_ff <= tgt_ff) begin
               fill_we = 1'b1;
               fill_wv = fill_cur + FW'(gap_ff);
               pos_in  = split_ff ? tgt_ff - 1'b1 : tgt_ff;
               state_in = ST_PUT;
            end else begin
               pos_in   = pos_ff - 1'b1;
               state_in = ST_SHIFT_WR;
            end
         end
         ST_SHIFT_WR: begin
            wr_en    = 1'b1;
            wr_addr  = {unit_ff, PW'(pos_ff + FW'(gap_ff))};
            wr_data  = rd_data;
            state_in = ST_SHIFT_RD;
         end
         ST_PUT: begin
            wr_en = 1'b1;
            if (func_ff == FUNC_PUSH) begin
               fill_we  = 1'b1;
               fill_wv  = fill_cur + 1'b1;
               state_in = ST_RESP;
            end else if (puts_ff == 2'd3) begin
               wr_data = old_ff;
               wr_data.length = clk_ff - old_ff.begin_clk;
               pos_in  = pos_ff + 1'b1;
               puts_in = 2'd2;
            end else if (puts_ff == 2'd2) begin
               pos_in  = pos_ff + 1'b1;
               puts_in = 2'd0;
            end else if (puts_ff == 2'd0) begin
               wr_data = old_ff;
               wr_data.begin_clk = clk_ff + nlen_ff;
               wr_data.length = old_ff.length - (clk_ff - old_ff.begin_clk);
               state_in = ST_RESP;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_REB_RD: begin
            if (pos_ff >= fill_cur) begin
               pos_in = '0;
               cur_in = clk_ff;
               if (32'(unit_ff) == 32'(NUM_UNITS - 1)) begin
                  state_in = ST_RESP;
               end else begin
                  unit_in = unit_ff + 1'b1;
               end
            end else begin
               state_in = ST_REB_WR;
            end
         end
         ST_REB_WR: begin
            wr_en   = 1'b1;
            wr_data = rd_data;
            wr_data.begin_clk = cur_ff;
            cur_in   = cur_ff + rd_data.length;
            pos_in   = pos_ff + 1'b1;
            state_in = ST_REB_RD;
         end
         ST_RESP: begin
            if (!rv_ff || rsp_ready) begin
               rv_in    = 1'b1;
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid        = rv_ff;
   assign rsp_status       = out_stat_ff;
   assign rsp_found_kind   = out_found_ff.kind;
   assign rsp_found_begin  = out_found_ff.begin_clk;
   assign rsp_found_length = out_found_ff.length;
   assign rsp_found_rowid  = out_found_ff.rowid;

endmodule

// File: rtl/puit_checker.sv
// ----------------------------------------------------------------------------
// puit_checker
// port-level checks on the command and response channels
// ----------------------------------------------------------------------------
module puit_checker
   import puit_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_status,
   input  logic [1:0]  rsp_found_kind,
   input  logic [31:0] rsp_found_length
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("response dropped while stalled");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid)
      else $error("command withdrawn before accept");

   a_found_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_found_kind) && $stable(rsp_found_length))
      else $error("found fields changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= STAT_FULL)
      else $error("bad status code");

   a_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_DONE |->
         rsp_found_kind == 2'd0 && rsp_found_length == 32'd0)
      else $error("found fields set on failure");

endmodule

bind per_unit_interval_timeline puit_checker u_puit_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_status       (rsp_status),
   .rsp_found_kind   (rsp_found_kind),
   .rsp_found_length (rsp_found_length)
);

// File: sim/tb_per_unit_interval_timeline.sv
// ----------------------------------------------------------------------------
// tb_per_unit_interval_timeline
// Self-checking bench for the per-unit interval timeline. It keeps its own
// copy of every unit's entry list and predicts the status and found fields
// of each command beat. Directed tests cover field extremes, splits, misses
// and full lists. A pressure test holds the response side while commands
// keep coming. Random tests mostly build coherent timelines and then insert
// and look up inside them. Both sides idle in random bursts, except at the end.
// ----------------------------------------------------------------------------
module tb_per_unit_interval_timeline;
   import puit_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned UNITS = 16;
   localparam int unsigned DEPTH = 32;
   localparam int unsigned STALL_LIMIT = 20000;

   typedef struct packed {
      status_type  status;
      logic [1:0]  kind;
      logic [31:0] begin_clk;
      logic [31:0] length;
      logic [15:0] rowid;
   } outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_func = '0;
   logic [3:0]  req_unit_index = '0;
   logic [1:0]  req_entry_kind = '0;
   logic [31:0] req_entry_begin = '0;
   logic [31:0] req_entry_length = '0;
   logic [15:0] req_entry_rowid = '0;
   logic [31:0] req_at_clock = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [1:0]  rsp_found_kind;
   logic [31:0] rsp_found_begin;
   logic [31:0] rsp_found_length;
   logic [15:0] rsp_found_rowid;

   slot_type    timeline [UNITS][DEPTH];
   int unsigned fill_count [UNITS];
   outcome_type pending_outcomes [$];
   int          error_count = 0;
   bit          quiet_mode = 1'b0;
   bit          hold_rsp = 1'b0;
   int unsigned stall_cycles = 0;

   per_unit_interval_timeline #(.NUM_UNITS(UNITS), .LIST_DEPTH(DEPTH)) uut (.*);

   always #5 clock = ~clock;

   function automatic int cover_index(int unsigned u, logic [31:0] c);
      for (int unsigned i = 0; i < fill_count[u]; i++) begin
         if (c >= timeline[u][i].begin_clk &&
             (c - timeline[u][i].begin_clk) < timeline[u][i].length)
            return i;
      end
      return -1;
   endfunction

   function automatic void predict_outcome(func_type f, int unsigned u, logic [1:0] k,
                                           logic [31:0] nb, logic [31:0] nl,
                                           logic [15:0] row, logic [31:0] c);
      outcome_type o;
      slot_type    fresh;
      slot_type    old;
      int          p;
      logic [31:0] head;
      logic [31:0] cur;
      o = '{STAT_DONE, 2'd0, 32'd0, 32'd0, 16'd0};
      fresh = '{k, nb, nl, row};
      case (f)
         FUNC_PUSH: begin
            if (u >= UNITS || fill_count[u] >= DEPTH) o.status = STAT_FULL;
            else begin
               timeline[u][fill_count[u]] = fresh;
               fill_count[u]++;
            end
         end
         FUNC_INSERT: begin
            p = (u < UNITS) ? cover_index(u, c) : -1;
            if (p < 0) o.status = STAT_NONE;
            else if (c == timeline[u][p].begin_clk) begin
               if (fill_count[u] + 1 > DEPTH) o.status = STAT_FULL;
               else begin
                  for (int i = int'(fill_count[u]) - 1; i >= p; i--)
                     timeline[u][i+1] = timeline[u][i];
                  timeline[u][p] = fresh;
                  fill_count[u]++;
               end
            end else if (fill_count[u] + 2 > DEPTH) o.status = STAT_FULL;
            else begin
               old = timeline[u][p];
               head = c - old.begin_clk;
               for (int i = int'(fill_count[u]) - 1; i > p; i--)
                  timeline[u][i+2] = timeline[u][i];
               timeline[u][p].length = head;
               timeline[u][p+1] = fresh;
               timeline[u][p+2] = '{old.kind, c + nl, old.length - head, old.rowid};
               fill_count[u] += 2;
            end
         end
         FUNC_REBASE: begin
            for (int unsigned v = 0; v < UNITS; v++) begin
               cur = c;
               for (int unsigned i = 0; i < fill_count[v]; i++) begin
                  timeline[v][i].begin_clk = cur;
                  cur += timeline[v][i].length;
               end
            end
         end
         default: begin
            p = (u < UNITS) ? cover_index(u, c) : -1;
            if (p < 0) o.status = STAT_NONE;
            else begin
               o.kind = timeline[u][p].kind;
               o.begin_clk = timeline[u][p].begin_clk;
               o.length = timeline[u][p].length;
               o.rowid = timeline[u][p].rowid;
            end
         end
      endcase
      pending_outcomes = {pending_outcomes, o};
   endfunction

   task automatic send_command(func_type f, logic [3:0] u, logic [1:0] k, logic [31:0] nb,
                               logic [31:0] nl, logic [15:0] row, logic [31:0] c);
      @(negedge clock);
      req_func = f;
      req_unit_index = u;
      req_entry_kind = k;
      req_entry_begin = nb;
      req_entry_length = nl;
      req_entry_rowid = row;
      req_at_clock = c;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_outcome(f, 32'(u), k, nb, nl, row, c);
      if (!quiet_mode && $urandom_range(0, 4) == 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   // clock inside some entry of the unit, or at its start, or anywhere
   function automatic logic [31:0] probe_clock(int unsigned u);
      int unsigned i;
      if (fill_count[u] == 0 || $urandom_range(0, 9) == 0) return $urandom;
      i = $urandom_range(0, fill_count[u] - 1);
      if (timeline[u][i].length == 0 || $urandom_range(0, 3) == 0)
         return timeline[u][i].begin_clk;
      return timeline[u][i].begin_clk + ($urandom % timeline[u][i].length);
   endfunction

   always @(posedge clock) begin
      outcome_type e;
      if (rsp_valid && rsp_ready) begin
         if (pending_outcomes.size() == 0) begin
            $error("response beat with nothing expected");
            error_count++;
         end else begin
            e = pending_outcomes.pop_front();
            if (rsp_status !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_status);
               error_count++;
            end
            if (rsp_found_kind !== e.kind) begin
               $error("found_kind expected %0d actual %0d", e.kind, rsp_found_kind);
               error_count++;
            end
            if (rsp_found_begin !== e.begin_clk) begin
               $error("found_begin expected %h actual %h", e.begin_clk, rsp_found_begin);
               error_count++;
            end
            if (rsp_found_length !== e.length) begin
               $error("found_length expected %h actual %h", e.length, rsp_found_length);
               error_count++;
            end
            if (rsp_found_rowid !== e.rowid) begin
               $error("found_rowid expected %h actual %h", e.rowid, rsp_found_rowid);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ready = 1'b0;
            repeat (300) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (quiet_mode || $urandom_range(0, 3) != 0) begin
            rsp_ready = 1'b1;
            @(negedge clock);
         end else begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
      end
   end

   task automatic test_directed_basic();
      send_command(FUNC_LOOKUP, 4'd15, 2'd0, 32'd0, 32'd0, 16'd0, 32'd0);
      send_command(FUNC_INSERT, 4'd15, 2'd1, 32'd5, 32'd5, 16'd1, 32'd0);
      send_command(FUNC_PUSH, 4'd15, 2'd3, 32'd0, 32'hFFFF_FFFF, 16'hFFFF, 32'd0);
      send_command(FUNC_PUSH, 4'd15, 2'd2, 32'hFFFF_FFFF, 32'd1, 16'd0, 32'd0);
      send_command(FUNC_PUSH, 4'd15, 2'd1, 32'd100, 32'd0, 16'h5A5A, 32'd0);
      send_command(FUNC_LOOKUP, 4'd15, 2'd0, 32'd0, 32'd0, 16'd0, 32'd0);
      send_command(FUNC_LOOKUP, 4'd15, 2'd0, 32'd0, 32'd0, 16'd0, 32'hFFFF_FFFE);
      send_command(FUNC_LOOKUP, 4'd15, 2'd0, 32'd0, 32'd0, 16'd0, 32'hFFFF_FFFF);
      send_command(FUNC_LOOKUP, 4'd15, 2'd0, 32'd0, 32'd0, 16'd0, 32'd100);
      send_command(FUNC_INSERT, 4'd15, 2'd0, 32'hAAAA_AAAA, 32'd7, 16'h1234, 32'd0);
      send_command(FUNC_INSERT, 4'd15, 2'd2, 32'h5555_5555, 32'hFFFF_FFF0, 16'hBEEF,
                   32'h8000_0000);
      send_command(FUNC_LOOKUP, 4'd15, 2'd0, 32'd0, 32'd0, 16'd0, 32'h8000_0000);
      send_command(FUNC_LOOKUP, 4'd15, 2'd0, 32'd0, 32'd0, 16'd0, 32'h7FFF_FFFF);
      send_command(FUNC_REBASE, 4'd0, 2'd0, 32'd0, 32'd0, 16'd0, 32'hFFFF_FFF0);
      send_command(FUNC_LOOKUP, 4'd15, 2'd0, 32'd0, 32'd0, 16'd0, 32'hFFFF_FFF3);
      send_command(FUNC_LOOKUP, 4'd15, 2'd0, 32'd0, 32'd0, 16'd0, 32'd3);
      send_command(FUNC_REBASE, 4'd0, 2'd0, 32'd0, 32'd0, 16'd0, 32'd0);
      send_command(FUNC_LOOKUP, 4'd15, 2'd0, 32'd0, 32'd0, 16'd0, 32'd7);
   endtask

   task automatic test_full_lists();
      for (int i = 0; i < 31; i++)
         send_command(FUNC_PUSH, 4'd14, 2'(i), 32'(i * 10), 32'd10, 16'(i), 32'd0);
      send_command(FUNC_INSERT, 4'd14, 2'd3, 32'd1, 32'd2, 16'd9, 32'd15);
      send_command(FUNC_INSERT, 4'd14, 2'd3, 32'd1, 32'd2, 16'd9, 32'd20);
      send_command(FUNC_PUSH, 4'd14, 2'd1, 32'd0, 32'd1, 16'd1, 32'd0);
      send_command(FUNC_INSERT, 4'd14, 2'd3, 32'd1, 32'd2, 16'd9, 32'd30);
      send_command(FUNC_INSERT, 4'd14, 2'd3, 32'd1, 32'd2, 16'd9, 32'd35);
      send_command(FUNC_LOOKUP, 4'd14, 2'd0, 32'd0, 32'd0, 16'd0, 32'd305);
   endtask

   task automatic random_command();
      int unsigned u;
      int unsigned pick;
      logic [31:0] nb;
      logic [31:0] nl;
      u = $urandom_range(0, UNITS - 1);
      pick = $urandom_range(0, 99);
      nl = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 60);
      if (fill_count[u] > 0 && $urandom_range(0, 4) != 0)
         nb = timeline[u][fill_count[u]-1].begin_clk + timeline[u][fill_count[u]-1].length;
      else nb = $urandom;
      if (pick < 35)
         send_command(FUNC_PUSH, 4'(u), 2'($urandom), nb, nl, 16'($urandom), $urandom);
      else if (pick < 65)
         send_command(FUNC_INSERT, 4'(u), 2'($urandom), $urandom, nl, 16'($urandom),
                      probe_clock(u));
      else if (pick < 96)
         send_command(FUNC_LOOKUP, 4'(u), 2'($urandom), $urandom, $urandom,
                      16'($urandom), probe_clock(u));
      else
         send_command(FUNC_REBASE, 4'($urandom), 2'($urandom), $urandom, $urandom,
                      16'($urandom), $urandom);
   endtask

   task automatic test_pressure();
      hold_rsp = 1'b1;
      for (int i = 0; i < 10; i++) begin
         @(negedge clock);
         send_command(FUNC_LOOKUP, 4'($urandom), 2'd0, 32'd0, 32'd0, 16'd0, $urandom);
      end
   endtask

   task automatic test_random(int n);
      repeat (n) random_command();
   endtask

   initial begin
      for (int unsigned v = 0; v < UNITS; v++) fill_count[v] = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed_basic();
      test_full_lists();
      quiet_mode = 1'b1;
      test_pressure();
      quiet_mode = 1'b0;
      test_random(1500);
      quiet_mode = 1'b1;
      test_random(300);
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
